FILE: hdl/dgnec_pkg.sv
// ---------------------------------------------------------------------------
// dgnec_pkg
// shared types and constants for the dot-gate netlist error checker
// ---------------------------------------------------------------------------
package dgnec_pkg;

    localparam int WORD_BITS  = 64;
    localparam int NODE_COUNT = 1024;
    localparam int ID_W       = $clog2(NODE_COUNT);
    localparam int CNT_W      = 32;
    localparam int POP_W      = $clog2(WORD_BITS + 1);
    localparam int CFG_W      = 10;

    // item operations
    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_GATE  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_ZERO_NODE = 1'b0,
        CFG_ONE_NODE  = 1'b1
    } t_cfg_index;

    // invert flag bit positions
    localparam int INV_X   = 0;
    localparam int INV_Y   = 1;
    localparam int INV_Z   = 2;
    localparam int INV_OUT = 3;

    typedef struct packed {
        t_mode                mode;
        logic [ID_W-1:0]      node_id;
        logic [ID_W-1:0]      fanin_x;
        logic [ID_W-1:0]      fanin_y;
        logic [ID_W-1:0]      fanin_z;
        logic [3:0]           invert_flags;
        logic [WORD_BITS-1:0] value_word;
        logic                 end_of_pattern;
    } t_in_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] result_word;
        logic [CNT_W-1:0]     pattern_errors;
        logic [CNT_W-1:0]     bit_errors;
    } t_out_item;

endpackage

FILE: hdl/dot_gate_netlist_error_checker_core.sv
// ---------------------------------------------------------------------------
// dot_gate_netlist_error_checker_core
// bit-parallel dot-gate netlist simulator with saturating error counters
// ---------------------------------------------------------------------------
// One input beat is taken per clock while o_in_stall is low, and each one
// gives exactly one result beat. The node store is read at the edge that
// accepts the beat into the evaluate stage, which evaluates the gate
// (x ^ (z | (x & y)) with optional inversions) or compares against the
// golden word; the result register is loaded as the stage advances, which
// waits while a stalled result is held. Dependent items may follow back to
// back: the word written by the item just ahead is forwarded around the node
// store. Throughput is one item per cycle while the result channel does not
// stall, set by the evaluate stage and the one write port of the node store;
// the store is kept as three identical copies so that the three gate operands
// are read in the same cycle. Node words come out of reset undefined; read
// only nodes that have been loaded or computed, or the two constant nodes.
// Configuration writes are taken at any edge but are meant for an idle block.
module dot_gate_netlist_error_checker_core
    import dgnec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  t_cfg_index       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    // input channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item
);

    // configuration registers
    logic [ID_W-1:0] r_zero_node;
    logic [ID_W-1:0] r_one_node;

    // evaluate stage
    logic     r_s1_valid;
    t_in_item r_s1;

    // node store, three copies with one read port each
    logic [WORD_BITS-1:0] r_mem_x [NODE_COUNT];
    logic [WORD_BITS-1:0] r_mem_y [NODE_COUNT];
    logic [WORD_BITS-1:0] r_mem_z [NODE_COUNT];
    logic [WORD_BITS-1:0] r_rd_x;
    logic [WORD_BITS-1:0] r_rd_y;
    logic [WORD_BITS-1:0] r_rd_z;

    // most recent node write, for forwarding
    logic                 r_wr_valid;
    logic [ID_W-1:0]      r_wr_addr;
    logic [WORD_BITS-1:0] r_wr_data;

    // error state
    logic [WORD_BITS-1:0] r_pat_mask;
    logic [CNT_W-1:0]     r_pat_cnt;
    logic [CNT_W-1:0]     r_bit_cnt;
    logic [WORD_BITS-1:0] n_pat_mask;
    logic [CNT_W-1:0]     n_pat_cnt;
    logic [CNT_W-1:0]     n_bit_cnt;

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    logic                 in_acc;
    logic                 s1_adv;
    logic [ID_W-1:0]      rd_addr_x;
    logic                 wr_en;
    logic [WORD_BITS-1:0] res_word;
    logic [WORD_BITS-1:0] op_x;
    logic [WORD_BITS-1:0] op_y;
    logic [WORD_BITS-1:0] op_z;
    logic [WORD_BITS-1:0] gate_word;
    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS-1:0] mask_or;

    // popcount as a six-level adder tree
    function automatic logic [POP_W-1:0] pop64(input logic [WORD_BITS-1:0] v);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++) begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input logic [POP_W-1:0] n);
        logic [CNT_W:0] sum;
        sum = {1'b0, c} + {{(CNT_W + 1 - POP_W){1'b0}}, n};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    // constant nodes first, then the newest write, then the store
    function automatic logic [WORD_BITS-1:0] node_word(
        input logic [ID_W-1:0]      id,
        input logic [WORD_BITS-1:0] mem_word,
        input logic [ID_W-1:0]      zero_id,
        input logic [ID_W-1:0]      one_id,
        input logic                 fwd_valid,
        input logic [ID_W-1:0]      fwd_addr,
        input logic [WORD_BITS-1:0] fwd_data
    );
        if (id == zero_id) begin
            return '0;
        end else if (id == one_id) begin
            return '1;
        end else if (fwd_valid && id == fwd_addr) begin
            return fwd_data;
        end
        return mem_word;
    endfunction

    // handshake: the evaluate stage moves on when the result register frees
    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_node <= '0;
            r_one_node  <= ID_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ZERO_NODE: r_zero_node <= i_cfg_data[ID_W-1:0];
                CFG_ONE_NODE:  r_one_node  <= i_cfg_data[ID_W-1:0];
                default:       ;
            endcase
        end
    end

    // the x copy also serves the source node of an output check
    assign rd_addr_x = (i_in_item.mode == MODE_CHECK) ? i_in_item.node_id
                                                      : i_in_item.fanin_x;

    assign wr_en = s1_adv && (r_s1.mode == MODE_LOAD || r_s1.mode == MODE_GATE);

    // node store: write from the evaluate stage, read on the accepting edge
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_x[r_s1.node_id] <= res_word;
        end
        if (in_acc) begin
            r_rd_x <= r_mem_x[rd_addr_x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_y[r_s1.node_id] <= res_word;
        end
        if (in_acc) begin
            r_rd_y <= r_mem_y[i_in_item.fanin_y];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_z[r_s1.node_id] <= res_word;
        end
        if (in_acc) begin
            r_rd_z <= r_mem_z[i_in_item.fanin_z];
        end
    end

    // forwarding register: the store reads old data on a same-edge write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else if (wr_en) begin
            r_wr_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wr_addr <= r_s1.node_id;
            r_wr_data <= res_word;
        end
    end

    // evaluate stage capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= i_in_item;
        end
    end

    // operand words, inversions and the dot gate
    always_comb begin
        op_x = node_word(r_s1.mode == MODE_CHECK ? r_s1.node_id : r_s1.fanin_x,
                         r_rd_x, r_zero_node, r_one_node,
                         r_wr_valid, r_wr_addr, r_wr_data);
        op_y = node_word(r_s1.fanin_y, r_rd_y, r_zero_node, r_one_node,
                         r_wr_valid, r_wr_addr, r_wr_data);
        op_z = node_word(r_s1.fanin_z, r_rd_z, r_zero_node, r_one_node,
                         r_wr_valid, r_wr_addr, r_wr_data);
    end

    always_comb begin
        logic [WORD_BITS-1:0] gx;
        logic [WORD_BITS-1:0] gy;
        logic [WORD_BITS-1:0] gz;
        gx        = op_x ^ {WORD_BITS{r_s1.invert_flags[INV_X]}};
        gy        = op_y ^ {WORD_BITS{r_s1.invert_flags[INV_Y]}};
        gz        = op_z ^ {WORD_BITS{r_s1.invert_flags[INV_Z]}};
        gate_word = (gx ^ (gz | (gx & gy))) ^ {WORD_BITS{r_s1.invert_flags[INV_OUT]}};
    end

    // error bookkeeping; op_x carries the checked node on a check
    assign diff    = op_x ^ r_s1.value_word;
    assign mask_or = r_pat_mask | diff;

    always_comb begin
        res_word   = '0;
        n_pat_mask = r_pat_mask;
        n_pat_cnt  = r_pat_cnt;
        n_bit_cnt  = r_bit_cnt;
        unique case (r_s1.mode)
            MODE_LOAD: begin
                res_word = r_s1.value_word;
            end
            MODE_GATE: begin
                res_word = gate_word;
            end
            MODE_CHECK: begin
                res_word  = op_x;
                n_bit_cnt = sat_add(r_bit_cnt, pop64(diff));
                if (r_s1.end_of_pattern) begin
                    n_pat_cnt  = sat_add(r_pat_cnt, pop64(mask_or));
                    n_pat_mask = '0;
                end else begin
                    n_pat_mask = mask_or;
                end
            end
            MODE_CLEAR: begin
                n_pat_mask = '0;
                n_pat_cnt  = '0;
                n_bit_cnt  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_mask <= '0;
            r_pat_cnt  <= '0;
            r_bit_cnt  <= '0;
        end else if (s1_adv) begin
            r_pat_mask <= n_pat_mask;
            r_pat_cnt  <= n_pat_cnt;
            r_bit_cnt  <= n_bit_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.result_word    <= res_word;
            r_out.pattern_errors <= n_pat_cnt;
            r_out.bit_errors     <= n_bit_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a held evaluate stage keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1))
        else $error("evaluate stage lost its item while held");

    // a check never lowers the bit error count
    a_bit_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1.mode == MODE_CHECK |=> r_bit_cnt >= $past(r_bit_cnt))
        else $error("bit error count went down on a check");

    // end of pattern empties the mask
    a_eop_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1.mode == MODE_CHECK && r_s1.end_of_pattern |=> r_pat_mask == '0)
        else $error("pattern mask not cleared at end of pattern");

    // clear empties all error state
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && r_s1.mode == MODE_CLEAR
        |=> r_pat_mask == '0 && r_pat_cnt == '0 && r_bit_cnt == '0)
        else $error("clear left error state behind");

endmodule

FILE: sim/tb_dot_gate_netlist_error_checker_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dot_gate_netlist_error_checker_core
// self-checking bench for the dot-gate netlist error checker
// ---------------------------------------------------------------------------
// Drives load, gate, check and clear beats into the core and predicts every
// result beat with a behavioral model of the node store, the per-pattern
// error mask and the two saturating counters. Stimulus starts with directed
// beats (operand extremes, constant nodes, inversions, pattern marks), walks
// the constant-node registers through several settings, then runs random
// netlist sweeps (loads, gates in topological order, output checks closing
// a pattern) mixed with unstructured traffic. Both channels idle in random
// bursts in the random stretches, not in the directed beats or the closing stretch.
// ---------------------------------------------------------------------------
module tb_dot_gate_netlist_error_checker_core;
    import dgnec_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTS     = 30;
    // two views of the node store: one follows accepted beats, one follows
    // the beats already planned so goldens and operands can be chosen
    localparam int PREDICT_VIEW   = 0;
    localparam int PLAN_VIEW      = 1;

    // ------------------------------------------------------------------
    // dut ports
    // ------------------------------------------------------------------
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    t_cfg_index       i_cfg_index = CFG_ZERO_NODE;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_item   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_item;

    dot_gate_netlist_error_checker_core dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor state
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0] node_store [2][NODE_COUNT];
    logic [WORD_BITS-1:0] err_mask    = '0;
    logic [CNT_W-1:0]     pat_err_cnt = '0;
    logic [CNT_W-1:0]     bit_err_cnt = '0;
    logic [ID_W-1:0]      cfg_zero_id = ID_W'(0);
    logic [ID_W-1:0]      cfg_one_id  = ID_W'(1);

    // planner bookkeeping: which nodes hold a defined word
    bit                   ever_written [NODE_COUNT];
    logic [ID_W-1:0]      written_ids [$];
    logic [ID_W-1:0]      recent_ids [$];

    t_out_item            expected_beats [$];
    int unsigned          items_taken  = 0;
    int unsigned          results_seen = 0;
    int unsigned          mismatches   = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          mode_seen [4];
    int unsigned          n_settings   = 1;

    // idling knobs
    bit                   idling_allowed = 1'b1;
    bit                   sender_gaps    = 1'b0;
    bit                   sink_stalls    = 1'b0;
    int unsigned          stall_left     = 0;

    // ------------------------------------------------------------------
    // model helpers
    // ------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                 input int unsigned n);
        logic [CNT_W:0] s;
        s = {1'b0, c} + n;
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // constant nodes win over whatever the store holds; zero wins a tie
    function automatic logic [WORD_BITS-1:0] read_word(input int view,
                                                       input logic [ID_W-1:0] id);
        if (id == cfg_zero_id)
            return '0;
        if (id == cfg_one_id)
            return '1;
        return node_store[view][id];
    endfunction

    function automatic logic [WORD_BITS-1:0] dot_gate(input logic [WORD_BITS-1:0] x,
                                                      input logic [WORD_BITS-1:0] y,
                                                      input logic [WORD_BITS-1:0] z,
                                                      input logic [3:0] inv);
        logic [WORD_BITS-1:0] xv, yv, zv, r;
        xv = inv[INV_X] ? ~x : x;
        yv = inv[INV_Y] ? ~y : y;
        zv = inv[INV_Z] ? ~z : z;
        r  = xv ^ (zv | (xv & yv));
        return inv[INV_OUT] ? ~r : r;
    endfunction

    // advances the predicted state by one accepted beat
    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item            r;
        logic [WORD_BITS-1:0] w, diff;
        w = '0;
        case (it.mode)
            MODE_LOAD: begin
                w = it.value_word;
                node_store[PREDICT_VIEW][it.node_id] = w;
            end
            MODE_GATE: begin
                w = dot_gate(read_word(PREDICT_VIEW, it.fanin_x),
                             read_word(PREDICT_VIEW, it.fanin_y),
                             read_word(PREDICT_VIEW, it.fanin_z), it.invert_flags);
                node_store[PREDICT_VIEW][it.node_id] = w;
            end
            MODE_CHECK: begin
                w           = read_word(PREDICT_VIEW, it.node_id);
                diff        = w ^ it.value_word;
                bit_err_cnt = sat_add(bit_err_cnt, $countones(diff));
                err_mask    = err_mask | diff;
                if (it.end_of_pattern) begin
                    pat_err_cnt = sat_add(pat_err_cnt, $countones(err_mask));
                    err_mask    = '0;
                end
            end
            default: begin
                err_mask    = '0;
                pat_err_cnt = '0;
                bit_err_cnt = '0;
            end
        endcase
        r.result_word    = w;
        r.pattern_errors = pat_err_cnt;
        r.bit_errors     = bit_err_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
                                   input logic [WORD_BITS-1:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // scoreboard: results are checked before the same edge's input beat is
    // predicted, so one block owns the queue and the order is fixed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    o_out_item.result_word, '0);
                end else begin
                    want = expected_beats.pop_front();
                    if (o_out_item.result_word !== want.result_word)
                        report_mismatch("result_word", o_out_item.result_word,
                                        want.result_word);
                    if (o_out_item.pattern_errors !== want.pattern_errors)
                        report_mismatch("pattern_errors", o_out_item.pattern_errors,
                                        want.pattern_errors);
                    if (o_out_item.bit_errors !== want.bit_errors)
                        report_mismatch("bit_errors", o_out_item.bit_errors,
                                        want.bit_errors);
                end
                results_seen <= results_seen + 1;
            end
            if (i_in_valid && !o_in_stall) begin
                expected_beats = {expected_beats, predict_result(i_in_item)};
                mode_seen[i_in_item.mode] += 1;
                items_taken <= items_taken + 1;
            end
        end
    end

    // sink stalls come in bursts of random length
    always @(posedge i_clk) begin
        if (sink_stalls && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 8);
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog: too long with no beat moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("FAIL dot_gate_netlist_error_checker_core");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    // any node whose read is defined: a constant or one already written
    function automatic logic [ID_W-1:0] pick_readable();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return cfg_zero_id;
        if (r < 16)
            return cfg_one_id;
        if (r < 66 && recent_ids.size() != 0)
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        return written_ids[$urandom_range(0, written_ids.size() - 1)];
    endfunction

    // unused fields stay random so ignored flags and marks get exercised
    function automatic t_in_item random_item(input t_mode m);
        t_in_item it;
        it.mode           = m;
        it.node_id        = $urandom_range(0, NODE_COUNT - 1);
        it.fanin_x        = $urandom_range(0, NODE_COUNT - 1);
        it.fanin_y        = $urandom_range(0, NODE_COUNT - 1);
        it.fanin_z        = $urandom_range(0, NODE_COUNT - 1);
        it.invert_flags   = $urandom_range(0, 15);
        it.value_word     = {$urandom, $urandom};
        it.end_of_pattern = $urandom_range(0, 1);
        if (m == MODE_GATE) begin
            it.fanin_x = pick_readable();
            it.fanin_y = pick_readable();
            it.fanin_z = pick_readable();
        end else if (m == MODE_CHECK) begin
            it.node_id = pick_readable();
        end
        return it;
    endfunction

    // golden word: often right, sometimes one to three bits off, sometimes random or inverted
    function automatic logic [WORD_BITS-1:0] near_golden(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] g;
        int r;
        g = w;
        r = $urandom_range(0, 19);
        if (r >= 9 && r < 15)
            repeat ($urandom_range(1, 3)) g[$urandom_range(0, WORD_BITS - 1)] ^= 1'b1;
        else if (r >= 15 && r < 18)
            g = {$urandom, $urandom};
        else if (r >= 18)
            g = ~w;
        return g;
    endfunction

    function automatic void plan_write(input logic [ID_W-1:0] id,
                                       input logic [WORD_BITS-1:0] w);
        node_store[PLAN_VIEW][id] = w;
        if (!ever_written[id]) begin
            ever_written[id] = 1'b1;
            written_ids = {written_ids, id};
        end
        recent_ids = {recent_ids, id};
        if (recent_ids.size() > 6)
            void'(recent_ids.pop_front());
    endfunction

    // drives one beat and returns at the edge that takes it
    task automatic send_item(input t_in_item it);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        if (it.mode == MODE_LOAD)
            plan_write(it.node_id, it.value_word);
        else if (it.mode == MODE_GATE)
            plan_write(it.node_id, dot_gate(read_word(PLAN_VIEW, it.fanin_x),
                                            read_word(PLAN_VIEW, it.fanin_y),
                                            read_word(PLAN_VIEW, it.fanin_z),
                                            it.invert_flags));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_load(input logic [ID_W-1:0] id, input logic [WORD_BITS-1:0] w);
        t_in_item it;
        it            = random_item(MODE_LOAD);
        it.node_id    = id;
        it.value_word = w;
        send_item(it);
    endtask

    task automatic send_gate(input logic [ID_W-1:0] id, input logic [ID_W-1:0] x,
                             input logic [ID_W-1:0] y, input logic [ID_W-1:0] z,
                             input logic [3:0] inv);
        t_in_item it;
        it              = random_item(MODE_GATE);
        it.node_id      = id;
        it.fanin_x      = x;
        it.fanin_y      = y;
        it.fanin_z      = z;
        it.invert_flags = inv;
        send_item(it);
    endtask

    task automatic send_check(input logic [ID_W-1:0] id, input logic [WORD_BITS-1:0] golden,
                              input logic eop);
        t_in_item it;
        it                = random_item(MODE_CHECK);
        it.node_id        = id;
        it.value_word     = golden;
        it.end_of_pattern = eop;
        send_item(it);
    endtask

    // sender holds off until every beat sent so far has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (results_seen < items_taken) @(posedge i_clk);
    endtask

    // constant-node registers only change on an idle core
    task automatic set_constants(input logic [ID_W-1:0] zero_id, input logic [ID_W-1:0] one_id);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ZERO_NODE;
        i_cfg_data  <= zero_id;
        @(posedge i_clk);
        i_cfg_index <= CFG_ONE_NODE;
        i_cfg_data  <= one_id;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_zero_id = zero_id;
        cfg_one_id  = one_id;
        n_settings++;
    endtask

    // one netlist sweep: primary inputs, gates in order, outputs checked,
    // the last check closing the pattern word
    task automatic run_episode();
        int unsigned     n_in, n_gate, n_chk;
        logic [ID_W-1:0] outs [$];
        logic [ID_W-1:0] id;
        n_in        = $urandom_range(2, 6);
        n_gate      = $urandom_range(3, 10);
        n_chk       = $urandom_range(1, 4);
        sender_gaps = idling_allowed && ($urandom_range(0, 2) != 0);
        sink_stalls = idling_allowed && ($urandom_range(0, 2) != 0);
        repeat (n_in) send_load($urandom_range(0, NODE_COUNT - 1), {$urandom, $urandom});
        repeat (n_gate) begin
            id = $urandom_range(0, NODE_COUNT - 1);
            send_gate(id, pick_readable(), pick_readable(), pick_readable(),
                      $urandom_range(0, 15));
            outs = {outs, id};
        end
        for (int i = 0; i < n_chk; i++) begin
            id = outs[$urandom_range(0, outs.size() - 1)];
            send_check(id, near_golden(read_word(PLAN_VIEW, id)), i == n_chk - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_ops();
        send_load(2, '1);
        send_load(3, 64'hAAAA_AAAA_AAAA_AAAA);
        send_load(1023, '0);
        send_load(512, 64'h0123_4567_89AB_CDEF);
        send_gate(4, 2, 3, 1023, 4'b0000);
        send_gate(5, 3, 512, 4, 4'b1111);
        // constant x and y operands, y inverted
        send_gate(6, 0, 1, 512, 4'b0010);
        // writes to the constant nodes land in the store, reads still see constants
        send_load(0, '1);
        send_load(1, '0);
        send_gate(7, 1, 1, 0, 4'b0000);
        // z input inverted, fed from a word written by a gate
        send_gate(8, 0, 0, 5, 4'b0100);
        // back to back on the word just produced
        send_gate(9, 8, 8, 8, 4'b0001);
        send_check(4, read_word(PLAN_VIEW, 4), 1'b0);
        send_check(5, ~read_word(PLAN_VIEW, 5), 1'b0);
        send_check(6, read_word(PLAN_VIEW, 6) ^ 64'h1, 1'b1);
        send_check(1023, '1, 1'b1);
        send_item(random_item(MODE_CLEAR));
        send_check(2, read_word(PLAN_VIEW, 2), 1'b1);
        send_check(9, near_golden(read_word(PLAN_VIEW, 9)), 1'b0);
        send_check(512, {$urandom, $urandom}, 1'b1);
    endtask

    task automatic test_const_node_config();
        // extremes swapped: top node reads zero, node 0 reads ones
        set_constants(1023, 0);
        send_gate(10, 1023, 0, 1, 4'b0000);
        send_check(1023, '1, 1'b0);
        send_check(0, read_word(PLAN_VIEW, 0), 1'b1);
        // both registers on one node: it reads as zero
        set_constants(7, 7);
        send_gate(11, 7, 7, 7, 4'b1000);
        send_gate(12, 0, 1023, 1, 4'b0000);
        send_check(7, '0, 1'b1);
        set_constants(1023, 1023);
        send_gate(13, 1023, 2, 1023, 4'b0101);
        send_check(13, read_word(PLAN_VIEW, 13), 1'b1);
    endtask

    task automatic test_netlist_random(input logic [ID_W-1:0] zero_id,
                                       input logic [ID_W-1:0] one_id, input int n_ep);
        set_constants(zero_id, one_id);
        repeat (n_ep) begin
            run_episode();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
    endtask

    // unstructured traffic: stray checks, marks across sweeps, clears
    task automatic test_noise_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0) begin
                sender_gaps = $urandom_range(0, 1);
                sink_stalls = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            if (r < 25)
                send_item(random_item(MODE_LOAD));
            else if (r < 55)
                send_item(random_item(MODE_GATE));
            else if (r < 92)
                send_item(random_item(MODE_CHECK));
            else
                send_item(random_item(MODE_CLEAR));
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_steady_stream(input int n_ep);
        idling_allowed = 1'b0;
        sender_gaps    = 1'b0;
        sink_stalls    = 1'b0;
        repeat (n_ep) run_episode();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [ID_W-1:0] same_id;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_const_node_config();
        test_netlist_random(0, 1, 40);
        test_netlist_random(1023, 0, 25);
        test_noise_random(300);
        test_netlist_random($urandom_range(0, NODE_COUNT - 1),
                            $urandom_range(0, NODE_COUNT - 1), 25);
        same_id = $urandom_range(0, NODE_COUNT - 1);
        test_netlist_random(same_id, same_id, 15);
        test_netlist_random(0, 1, 10);
        test_steady_stream(15);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_beats.size() != 0)
            report_mismatch("results never delivered",
                            WORD_BITS'(expected_beats.size()), '0);

        $display("covered %0d loads, %0d gate evaluations, %0d output checks, %0d clears",
                 mode_seen[MODE_LOAD], mode_seen[MODE_GATE], mode_seen[MODE_CHECK],
                 mode_seen[MODE_CLEAR]);
        $display("across %0d constant-node settings, %0d result beats compared",
                 n_settings, results_seen);
        if (mismatches == 0) begin
            $display("PASS dot_gate_netlist_error_checker_core");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL dot_gate_netlist_error_checker_core");
        end
        $finish;
    end

endmodule
